// ===== sv/tlc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tlc_pkg: shared types and constants of the TTL lookup cache
// Slot layout, table depth and field widths that several files use.
// ----------------------------------------------------------------------------
package tlc_pkg;

  localparam int DEPTH  = 16;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int CAP_W  = 5;
  localparam int OCC_W  = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  localparam logic MODE_LOOKUP = 1'b0;
  localparam logic MODE_INSERT = 1'b1;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_MISS = 1'b1;

  typedef struct packed {
    logic [15:0] record_type;
    logic [63:0] name_key;
    logic [63:0] answer;
    logic [31:0] expiry;
  } slot_t;

  typedef struct packed {
    logic [15:0] record_type;
    logic [63:0] name_key;
    logic [31:0] now;
  } probe_t;

  typedef struct packed {
    logic match;
    logic live;
  } cmp_res_t;

endpackage

`default_nettype wire

// ===== sv/tlc_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tlc_if: request and response channels of the TTL lookup cache
// Valid/ready channels; a word moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface tlc_req_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [15:0] record_type;
  logic [63:0] name_key;
  logic [63:0] answer_in;
  logic [31:0] ttl_seconds;
  logic [31:0] now;

  modport source (output valid, mode, record_type, name_key, answer_in, ttl_seconds, now,
                  input ready);
  modport sink (input valid, mode, record_type, name_key, answer_in, ttl_seconds, now,
                output ready);
endinterface

interface tlc_rsp_if;
  logic        valid;
  logic        ready;
  logic        status;
  logic [63:0] answer_out;
  logic [4:0]  occupancy;

  modport source (output valid, status, answer_out, occupancy, input ready);
  modport sink (input valid, status, answer_out, occupancy, output ready);
endinterface

`default_nettype wire

// ===== sv/tlc_slot_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tlc_slot_ram: slot storage of the TTL lookup cache
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tlc_slot_ram (
  input  wire                        clk,
  input  wire                        we,
  input  wire [tlc_pkg::ADDR_W-1:0]  waddr,
  input  wire tlc_pkg::slot_t        wdata,
  input  wire [tlc_pkg::ADDR_W-1:0]  raddr,
  output tlc_pkg::slot_t             rdata
);

  tlc_pkg::slot_t mem [tlc_pkg::DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== sv/tlc_cmp_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tlc_cmp_unit: slot compare unit
// Checks one slot against the probe: key match and expiry against now.
// ----------------------------------------------------------------------------
module tlc_cmp_unit (
  input  wire tlc_pkg::slot_t  slot,
  input  wire tlc_pkg::probe_t probe,
  output tlc_pkg::cmp_res_t    res
);

  assign res.match = (slot.record_type == probe.record_type) &&
                     (slot.name_key == probe.name_key);
  assign res.live  = (probe.now < slot.expiry);

endmodule

`default_nettype wire

// ===== sv/ttl_lookup_cache_fifo.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ttl_lookup_cache_fifo: bounded TTL cache with oldest-first eviction
// Sequencer that walks the slot memory through one shared compare unit.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one word per operation: a lookup (mode 0) or an insert
//   (mode 1). rsp returns one word per request with status, answer and the
//   occupancy after the operation. cfg_we/cfg_wdata set the capacity; write
//   it only while no request is in flight.
//   Operation, with n entries held: a lookup walks up to n slots oldest first
//   before its result goes to the response register. An
//   insert makes two passes over the slots (count the live entries, then
//   compact while dropping the expired and evicted ones) and one append
//   step. The one-read-port slot memory sets the pace of each pass:
//   one slot is examined per cycle. One request is worked on at a
//   time; req.ready is high only when the sequencer is idle.
//   The response sits in an output register, so the next request is taken
//   while a response waits; if the receiver stalls, the sequencer holds
//   the finished result until the register frees up.
//   Reset empties the cache and sets the capacity to 16; slot contents
//   need no clearing.
// ----------------------------------------------------------------------------
module ttl_lookup_cache_fifo (
  input  wire                       clk,
  input  wire                       rst,
  tlc_req_if.sink                   req,
  tlc_rsp_if.source                 rsp,
  input  wire                       cfg_we,
  input  wire [tlc_pkg::CAP_W-1:0]  cfg_wdata
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOK,
    ST_COUNT,
    ST_COPY,
    ST_APPEND,
    ST_REPORT
  } state_t;

  state_t                      state;
  logic [tlc_pkg::CAP_W-1:0]   cap;
  logic [tlc_pkg::CNT_W-1:0]   count;
  logic [tlc_pkg::CNT_W-1:0]   rd;
  logic [tlc_pkg::CNT_W-1:0]   wr;
  logic [tlc_pkg::CNT_W-1:0]   live_cnt;
  logic [tlc_pkg::CNT_W-1:0]   skip_left;
  logic                        pend;

  tlc_pkg::probe_t             probe;
  logic [63:0]                 answer_r;
  logic [31:0]                 ttl_r;
  logic                        status_r;
  logic [63:0]                 result_r;

  logic                        out_valid;
  logic                        out_status;
  logic [63:0]                 out_answer;
  logic [tlc_pkg::OCC_W-1:0]   out_occ;

  tlc_pkg::slot_t              rdata;
  tlc_pkg::slot_t              wdata;
  logic                        we;
  logic [tlc_pkg::ADDR_W-1:0]  waddr;
  tlc_pkg::cmp_res_t           res;

  logic                        issue;
  logic [tlc_pkg::CNT_W-1:0]   cap_eff;
  logic [tlc_pkg::CNT_W-1:0]   skip_calc;
  logic [32:0]                 expiry_sum;
  logic [31:0]                 expiry;

  tlc_slot_ram u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (rd[tlc_pkg::ADDR_W-1:0]),
    .rdata (rdata)
  );

  tlc_cmp_unit u_cmp (
    .slot  (rdata),
    .probe (probe),
    .res   (res)
  );

  // A scan issues one read per cycle until every held slot has been read or a lookup has found its match.
  assign issue = (rd < count);

  always_comb begin
    if (32'(cap) > tlc_pkg::DEPTH) begin
      cap_eff = tlc_pkg::CNT_W'(tlc_pkg::DEPTH);
    end else if (cap == '0) begin
      cap_eff = tlc_pkg::CNT_W'(1);
    end else begin
      cap_eff = tlc_pkg::CNT_W'(cap);
    end
    if (live_cnt >= cap_eff) begin
      skip_calc = live_cnt - cap_eff + tlc_pkg::CNT_W'(1);
    end else begin
      skip_calc = '0;
    end
  end

  assign expiry_sum = {1'b0, probe.now} + {1'b0, ttl_r};
  assign expiry     = expiry_sum[32] ? 32'hFFFF_FFFF : expiry_sum[31:0];

  always_comb begin
    we    = 1'b0;
    waddr = wr[tlc_pkg::ADDR_W-1:0];
    wdata = rdata;
    case (state)
      ST_COPY: begin
        we = pend && res.live && (skip_left == '0);
      end
      ST_APPEND: begin
        we    = 1'b1;
        wdata = '{record_type: probe.record_type, name_key: probe.name_key,
                  answer: answer_r, expiry: expiry};
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  assign req.ready      = (state == ST_IDLE);
  assign rsp.valid      = out_valid;
  assign rsp.status     = out_status;
  assign rsp.answer_out = out_answer;
  assign rsp.occupancy  = out_occ;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cap       <= tlc_pkg::CAP_RESET;
      count     <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        cap <= cfg_wdata;
      end
      // In ST_REPORT a new word may take the place of the one leaving.
      if (out_valid && rsp.ready && (state != ST_REPORT)) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (req.valid) begin
            probe.record_type <= req.record_type;
            probe.name_key    <= req.name_key;
            probe.now         <= req.now;
            answer_r          <= req.answer_in;
            ttl_r             <= req.ttl_seconds;
            rd                <= '0;
            wr                <= '0;
            live_cnt          <= '0;
            pend              <= 1'b0;
            state             <= (req.mode == tlc_pkg::MODE_INSERT) ? ST_COUNT : ST_LOOK;
          end
        end
        ST_LOOK: begin
          pend <= issue;
          if (issue) begin
            rd <= rd + tlc_pkg::CNT_W'(1);
          end
          // The oldest match decides, live or not.
          if (pend && res.match) begin
            status_r <= res.live ? tlc_pkg::STATUS_OK : tlc_pkg::STATUS_MISS;
            result_r <= res.live ? rdata.answer : 64'd0;
            state    <= ST_REPORT;
          end else if (!pend && !issue) begin
            status_r <= tlc_pkg::STATUS_MISS;
            result_r <= 64'd0;
            state    <= ST_REPORT;
          end
        end
        ST_COUNT: begin
          pend <= issue;
          if (issue) begin
            rd <= rd + tlc_pkg::CNT_W'(1);
          end
          if (pend && res.live) begin
            live_cnt <= live_cnt + tlc_pkg::CNT_W'(1);
          end
          if (!pend && !issue) begin
            skip_left <= skip_calc;
            rd        <= '0;
            state     <= ST_COPY;
          end
        end
        ST_COPY: begin
          pend <= issue;
          if (issue) begin
            rd <= rd + tlc_pkg::CNT_W'(1);
          end
          // Live entries move down; the oldest ones over capacity are dropped.
          if (pend && res.live) begin
            if (skip_left != '0) begin
              skip_left <= skip_left - tlc_pkg::CNT_W'(1);
            end else begin
              wr <= wr + tlc_pkg::CNT_W'(1);
            end
          end
          if (!pend && !issue) begin
            state <= ST_APPEND;
          end
        end
        ST_APPEND: begin
          count    <= wr + tlc_pkg::CNT_W'(1);
          status_r <= tlc_pkg::STATUS_OK;
          result_r <= 64'd0;
          state    <= ST_REPORT;
        end
        ST_REPORT: begin
          if (!out_valid || rsp.ready) begin
            out_valid  <= 1'b1;
            out_status <= status_r;
            out_answer <= result_r;
            out_occ    <= tlc_pkg::OCC_W'(count);
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_append_within_cap: assert property (@(posedge clk) disable iff (rst)
    (state == ST_APPEND) |=> (count != '0) && (count <= cap_eff))
    else $error("occupancy after insert outside 1..capacity");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> (state != ST_IDLE))
    else $error("accepted request did not start the sequencer");

  a_miss_has_zero_answer: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && (rsp.status == tlc_pkg::STATUS_MISS)) |-> (rsp.answer_out == 64'd0))
    else $error("miss response carries a nonzero answer");

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (count <= tlc_pkg::CNT_W'(tlc_pkg::DEPTH)))
    else $error("entry count exceeds table depth");

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking bench for the TTL lookup cache
// Drives lookups and inserts on the request channel and predicts every
// response word from a shadow copy of the cache. The capacity is changed
// between phases, with sender and receiver stalls and one long receiver hold.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned STALL_LIMIT = 3000;
  localparam int unsigned HOLD_CYCLES = 400;

  typedef struct packed {
    logic        mode;
    logic [15:0] record_type;
    logic [63:0] name_key;
    logic [63:0] answer_in;
    logic [31:0] ttl_seconds;
    logic [31:0] now;
  } cache_op_t;

  typedef struct packed {
    logic        status;
    logic [63:0] answer_out;
    logic [4:0]  occupancy;
  } cache_reply_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we;
  logic [tlc_pkg::CAP_W-1:0] cfg_wdata;

  tlc_req_if req_ch ();
  tlc_rsp_if rsp_ch ();

  ttl_lookup_cache_fifo dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch),
    .rsp       (rsp_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Operations waiting to be sent and the replies they are predicted to give.
  cache_op_t    cache_ops_q [$];
  cache_reply_t cache_replies_q [$];

  // Shadow of the cache: entries in insertion order, oldest first.
  tlc_pkg::slot_t            shadow_slots [$];
  logic [tlc_pkg::CAP_W-1:0] shadow_capacity = tlc_pkg::CAP_RESET;

  int unsigned snd_idle_pct = 13;
  int unsigned rcv_idle_pct = 55;
  int unsigned mismatch_count = 0;
  int unsigned reply_count = 0;
  int unsigned lookup_count = 0;
  int unsigned hit_count = 0;
  int unsigned insert_count = 0;
  int unsigned evict_count = 0;
  int unsigned peak_occupancy = 0;
  int unsigned hold_at = 32'hFFFF_FFFF;
  int unsigned hold_cnt = 0;
  logic        hold_done = 1'b0;
  int unsigned quiet_cycles = 0;
  logic        send_now;
  cache_reply_t got_reply;
  cache_reply_t want_reply;

  logic [31:0] sim_now = 32'd1000;
  logic [63:0] key_pool [8];
  logic [15:0] type_pool [4];

  function automatic cache_reply_t apply_cache_op(cache_op_t op);
    cache_reply_t   res;
    tlc_pkg::slot_t kept [$];
    tlc_pkg::slot_t entry;
    logic [32:0]    sum;
    int unsigned    cap;
    logic           found;
    res.status = tlc_pkg::STATUS_MISS;
    res.answer_out = '0;
    if (op.mode == tlc_pkg::MODE_LOOKUP) begin
      lookup_count++;
      found = 1'b0;
      // Only the oldest matching entry counts, live or not.
      for (int i = 0; i < shadow_slots.size() && !found; i++) begin
        if (shadow_slots[i].record_type == op.record_type &&
            shadow_slots[i].name_key == op.name_key) begin
          found = 1'b1;
          if (op.now < shadow_slots[i].expiry) begin
            res.status = tlc_pkg::STATUS_OK;
            res.answer_out = shadow_slots[i].answer;
            hit_count++;
          end
        end
      end
    end else begin
      insert_count++;
      cap = (shadow_capacity == 0) ? 1 :
            (shadow_capacity > tlc_pkg::DEPTH) ? tlc_pkg::DEPTH : shadow_capacity;
      foreach (shadow_slots[i])
        if (op.now < shadow_slots[i].expiry) kept.push_back(shadow_slots[i]);
      shadow_slots = kept;
      while (shadow_slots.size() >= cap) begin
        void'(shadow_slots.pop_front());
        evict_count++;
      end
      sum = {1'b0, op.now} + {1'b0, op.ttl_seconds};
      entry.record_type = op.record_type;
      entry.name_key = op.name_key;
      entry.answer = op.answer_in;
      entry.expiry = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
      shadow_slots.push_back(entry);
      res.status = tlc_pkg::STATUS_OK;
    end
    res.occupancy = 5'(shadow_slots.size());
    if (shadow_slots.size() > peak_occupancy) peak_occupancy = shadow_slots.size();
    return res;
  endfunction

  function automatic cache_op_t random_cache_op();
    cache_op_t   op;
    int unsigned pick;
    op.answer_in = {$urandom, $urandom};
    op.ttl_seconds = $urandom;
    if ($urandom_range(99) < 8) begin
      // Noise: every field drawn over its whole range.
      op.mode = 1'($urandom_range(1));
      op.record_type = 16'($urandom);
      op.name_key = {$urandom, $urandom};
      op.now = $urandom;
      return op;
    end
    pick = $urandom_range(99);
    if (pick < 2) sim_now = $urandom;
    else if (pick < 3) sim_now = 32'hFFFF_FFF0;
    else sim_now = sim_now + $urandom_range(4);
    op.now = sim_now;
    op.mode = ($urandom_range(99) < 50) ? tlc_pkg::MODE_INSERT : tlc_pkg::MODE_LOOKUP;
    op.record_type = type_pool[2'($urandom_range(3))];
    op.name_key = key_pool[3'($urandom_range(7))];
    if (op.mode == tlc_pkg::MODE_INSERT) begin
      pick = $urandom_range(99);
      if (pick < 55) op.ttl_seconds = $urandom_range(40);
      else if (pick < 80) op.ttl_seconds = $urandom_range(3000);
      else if (pick >= 90) op.ttl_seconds = 32'hFFFF_FFFF - $urandom_range(20);
    end
    return op;
  endfunction

  task automatic queue_op(input logic mode, input logic [15:0] rtype,
                          input logic [63:0] key, input logic [63:0] answer,
                          input logic [31:0] ttl, input logic [31:0] now);
    cache_op_t op;
    op.mode = mode;
    op.record_type = rtype;
    op.name_key = key;
    op.answer_in = answer;
    op.ttl_seconds = ttl;
    op.now = now;
    cache_ops_q.push_back(op);
  endtask

  task automatic queue_random(input int unsigned count);
    repeat (count) cache_ops_q.push_back(random_cache_op());
  endtask

  task automatic wait_drained();
    while (cache_ops_q.size() != 0 || cache_replies_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // The capacity may only change while no operation is in flight.
  task automatic set_capacity(input logic [tlc_pkg::CAP_W-1:0] cap);
    wait_drained();
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= cap;
    shadow_capacity = cap;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Request side: hold a word until it is taken, then maybe pause.
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        cache_replies_q.push_back(apply_cache_op(cache_ops_q[0]));
        void'(cache_ops_q.pop_front());
      end
      if (!req_ch.valid || req_ch.ready) begin
        send_now = cache_ops_q.size() != 0 && $urandom_range(99) >= snd_idle_pct;
        req_ch.valid <= send_now;
        if (send_now) begin
          req_ch.mode <= cache_ops_q[0].mode;
          req_ch.record_type <= cache_ops_q[0].record_type;
          req_ch.name_key <= cache_ops_q[0].name_key;
          req_ch.answer_in <= cache_ops_q[0].answer_in;
          req_ch.ttl_seconds <= cache_ops_q[0].ttl_seconds;
          req_ch.now <= cache_ops_q[0].now;
        end
      end
    end
  end

  // Response side: compare each word with the oldest prediction.
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        reply_count <= reply_count + 1;
        got_reply.status = rsp_ch.status;
        got_reply.answer_out = rsp_ch.answer_out;
        got_reply.occupancy = rsp_ch.occupancy;
        if (cache_replies_q.size() == 0) begin
          $display("%0t: unexpected response word, status %0d answer %h occupancy %0d",
                   $time, got_reply.status, got_reply.answer_out, got_reply.occupancy);
          mismatch_count++;
        end else begin
          want_reply = cache_replies_q.pop_front();
          if (got_reply.status !== want_reply.status) begin
            $display("%0t: status expected %0d, got %0d",
                     $time, want_reply.status, got_reply.status);
            mismatch_count++;
          end
          if (got_reply.answer_out !== want_reply.answer_out) begin
            $display("%0t: answer_out expected %h, got %h",
                     $time, want_reply.answer_out, got_reply.answer_out);
            mismatch_count++;
          end
          if (got_reply.occupancy !== want_reply.occupancy) begin
            $display("%0t: occupancy expected %0d, got %0d",
                     $time, want_reply.occupancy, got_reply.occupancy);
            mismatch_count++;
          end
        end
      end
      rsp_ch.ready <= hold_cnt == 0 && $urandom_range(99) >= rcv_idle_pct;
    end
  end

  // One long receiver hold so that the cache backs up onto its input.
  always @(posedge clk) begin
    if (rst) begin
      hold_cnt <= 0;
    end else if (!hold_done && reply_count >= hold_at) begin
      hold_cnt <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
    end
  end

  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: timeout, no word moved for %0d cycles", $time, quiet_cycles);
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    req_ch.valid = 1'b0;
    req_ch.mode = tlc_pkg::MODE_LOOKUP;
    req_ch.record_type = '0;
    req_ch.name_key = '0;
    req_ch.answer_in = '0;
    req_ch.ttl_seconds = '0;
    req_ch.now = '0;
    rsp_ch.ready = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    key_pool[0] = 64'h0;
    key_pool[1] = 64'hFFFF_FFFF_FFFF_FFFF;
    for (int i = 2; i < 8; i++) key_pool[3'(i)] = {$urandom, $urandom};
    type_pool[0] = 16'h0000;
    type_pool[1] = 16'hFFFF;
    type_pool[2] = 16'h0001;
    type_pool[3] = 16'h001C;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Hits, expiry at the boundary, saturated expiry and shadowed duplicates.
    queue_op(tlc_pkg::MODE_LOOKUP, 16'h0000, 64'h0, 64'h0, 32'h0, 32'd0);
    queue_op(tlc_pkg::MODE_INSERT, 16'h0000, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF,
             32'd10, 32'd100);
    queue_op(tlc_pkg::MODE_LOOKUP, 16'h0000, 64'h0, 64'h0, 32'h0, 32'd109);
    queue_op(tlc_pkg::MODE_LOOKUP, 16'h0000, 64'h0, 64'h0, 32'h0, 32'd110);
    queue_op(tlc_pkg::MODE_INSERT, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0,
             32'hFFFF_FFFF, 32'd5);
    queue_op(tlc_pkg::MODE_LOOKUP, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0,
             32'h0, 32'hFFFF_FFFE);
    queue_op(tlc_pkg::MODE_LOOKUP, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0,
             32'h0, 32'hFFFF_FFFF);
    queue_op(tlc_pkg::MODE_INSERT, 16'h0000, 64'h0, 64'h1234, 32'd1000, 32'd50);
    queue_op(tlc_pkg::MODE_LOOKUP, 16'h0000, 64'h0, 64'h0, 32'h0, 32'd120);
    queue_op(tlc_pkg::MODE_LOOKUP, 16'h0001, 64'h0, 64'h0, 32'h0, 32'd120);
    queue_op(tlc_pkg::MODE_LOOKUP, 16'h0000, 64'h1, 64'h0, 32'h0, 32'd120);
    // A zero lifetime gives an entry that is already expired on arrival.
    queue_op(tlc_pkg::MODE_INSERT, 16'h0007, 64'h7, 64'h7, 32'd0, 32'd200);
    queue_op(tlc_pkg::MODE_LOOKUP, 16'h0007, 64'h7, 64'h0, 32'h0, 32'd200);
    queue_op(tlc_pkg::MODE_LOOKUP, 16'h0000, 64'h0, 64'h0, 32'h0, 32'd200);
    queue_op(tlc_pkg::MODE_INSERT, 16'h0002, 64'h2, 64'h2, 32'd5, 32'hFFFF_FFFF);
    // Insert 17 entries, more than the table holds, so that older ones are evicted.
    for (int i = 0; i < 17; i++)
      queue_op(tlc_pkg::MODE_INSERT, 16'h0100, 64'h100 + i, {$urandom, $urandom},
               32'd100000, 32'd300);
    queue_op(tlc_pkg::MODE_LOOKUP, 16'h0100, 64'h100, 64'h0, 32'h0, 32'd300);
    queue_op(tlc_pkg::MODE_LOOKUP, 16'h0100, 64'h110, 64'h0, 32'h0, 32'd300);

    // Capacity dropped below the occupancy: only the next insert trims.
    set_capacity(5'd3);
    queue_op(tlc_pkg::MODE_LOOKUP, 16'h0100, 64'h105, 64'h0, 32'h0, 32'd300);
    queue_op(tlc_pkg::MODE_INSERT, 16'h0100, 64'h200, 64'h200, 32'd50, 32'd301);
    queue_op(tlc_pkg::MODE_LOOKUP, 16'h0100, 64'h105, 64'h0, 32'h0, 32'd301);
    queue_random(250);
    set_capacity(5'd0);
    queue_random(200);
    set_capacity(5'd31);
    snd_idle_pct = 55;
    rcv_idle_pct = 13;
    queue_random(300);
    set_capacity(5'd1);
    queue_random(150);
    set_capacity(5'd17);
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    queue_random(250);
    set_capacity(5'd16);
    hold_at = reply_count + 60;
    queue_random(350);
    set_capacity(5'd8);
    queue_random(250);

    wait_drained();
    repeat (60) @(posedge clk);
    $display("Checked %0d replies: %0d lookups with %0d hits, %0d inserts, %0d evictions.",
             reply_count, lookup_count, hit_count, insert_count, evict_count);
    $display("Capacities 16, 3, 0, 31, 1, 17, 16 and 8; peak occupancy %0d.", peak_occupancy);
    if (mismatch_count == 0 && cache_replies_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/tlc_pkg.sv
sv/tlc_if.sv
sv/tlc_slot_ram.sv
sv/tlc_cmp_unit.sv
sv/ttl_lookup_cache_fifo.sv
dv/tb.sv
